// File: hdl/sm4c_pkg.sv
// Package for the SM4 CBC block cipher: S-box, round constants, word transforms.
// Used by every module under hdl/ except sm4c_checker; no dependencies.
package sm4c_pkg;

    localparam int unsigned NumRounds = 32;
    localparam int unsigned RndW      = $clog2(NumRounds);
    localparam int unsigned AddrW     = 6;

    localparam logic [AddrW-1:0] RegKeyHigh = 6'h00;
    localparam logic [AddrW-1:0] RegKeyLow  = 6'h08;
    localparam logic [AddrW-1:0] RegIvHigh  = 6'h10;
    localparam logic [AddrW-1:0] RegIvLow   = 6'h18;
    localparam logic [AddrW-1:0] RegDir     = 6'h20;

    localparam logic [31:0] Fk0 = 32'ha3b1bac6;
    localparam logic [31:0] Fk1 = 32'h56aa3350;
    localparam logic [31:0] Fk2 = 32'h677d9197;
    localparam logic [31:0] Fk3 = 32'hb27022dc;

    // front-to-back queue entry
    typedef struct packed {
        logic [127:0] blk;
        logic         restart;
    } t_item;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] lin_data(input logic [31:0] b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK byte j of round i is (4*i + j) * 7 mod 256
    function automatic logic [31:0] round_const(input logic [RndW-1:0] i);
        logic [31:0] v;
        logic [7:0]  b;
        v = '0;
        for (int j = 0; j < 4; j++) begin
            b = 8'(({3'b000, i, 2'b00} + 8'(j)) * 8'd7);
            v = {v[23:0], b};
        end
        return v;
    endfunction

endpackage

// File: hdl/sm4c_front.sv
// Front end: takes input words into a two-entry queue toward the round engine.
// Depends on sm4c_pkg.
module sm4c_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sm4c_pkg::t_item     i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output sm4c_pkg::t_item     o_item
);
    import sm4c_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: hdl/sm4c_keyexp.sv
// Key expansion: one key round per cycle into a 32-word round key memory.
// Depends on sm4c_pkg.
module sm4c_keyexp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [127:0]                i_key,
    input  logic [sm4c_pkg::RndW-1:0]   i_rd_idx,
    output logic [31:0]                 o_rk,
    output logic                        o_busy
);
    import sm4c_pkg::*;

    logic [31:0]     r_rk [NumRounds];
    logic [31:0]     r_k0, r_k1, r_k2, r_k3;
    logic [RndW-1:0] r_idx;
    logic            r_busy;
    logic            r_wr_any;
    logic [31:0]     nk;

    assign nk     = r_k0 ^ lin_key(tau(r_k1 ^ r_k2 ^ r_k3 ^ round_const(r_idx)));
    assign o_busy = r_busy;

    // memory read is registered; the engine addresses the next round's key while the current round runs
    always_ff @(posedge i_clk) begin
        if (r_busy) r_rk[r_idx] <= nk;
        o_rk <= r_wr_any ? r_rk[i_rd_idx] : 32'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_wr_any <= 1'b0;
            r_idx    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_k0   <= i_key[127:96] ^ Fk0;
            r_k1   <= i_key[95:64]  ^ Fk1;
            r_k2   <= i_key[63:32]  ^ Fk2;
            r_k3   <= i_key[31:0]   ^ Fk3;
        end else if (r_busy) begin
            r_k0 <= r_k1;
            r_k1 <= r_k2;
            r_k2 <= r_k3;
            r_k3 <= nk;
            r_idx <= r_idx + 1'b1;
            if (r_idx == RndW'(NumRounds - 1)) begin
                r_busy   <= 1'b0;
                r_wr_any <= 1'b1;
            end
        end
    end
endmodule

// File: hdl/sm4c_engine.sv
// Back end: CBC chaining and the SM4 data rounds, one round per cycle.
// Depends on sm4c_pkg; round keys come from sm4c_keyexp.
module sm4c_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  sm4c_pkg::t_item             i_item,
    input  logic                        i_hold,
    input  logic                        i_dir,
    input  logic [127:0]                i_iv,
    output logic [sm4c_pkg::RndW-1:0]   o_rk_idx,
    input  logic [31:0]                 i_rk,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [127:0]                o_blk
);
    import sm4c_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_ROUND} t_state;

    t_state          r_state;
    logic [RndW-1:0] r_rnd;
    logic [31:0]     r_x0, r_x1, r_x2, r_x3;
    logic [127:0]    r_chain, r_cin;
    logic            r_dec;
    logic            r_oval;
    logic [127:0]    r_out;
    logic [127:0]    chain_use, blk_in;
    logic [31:0]     nx;
    logic [RndW-1:0] rd_rnd;

    assign chain_use = i_item.restart ? i_iv : r_chain;
    assign blk_in    = i_dir ? (i_item.blk ^ chain_use) : i_item.blk;
    assign nx        = r_x0 ^ lin_data(tau(r_x1 ^ r_x2 ^ r_x3 ^ i_rk));
    // key address for the round after the one in flight
    assign rd_rnd    = (r_state == S_ROUND) ? r_rnd + 1'b1 : '0;
    assign o_rk_idx  = r_dec ? ~rd_rnd : rd_rnd;

    // start only when the output slot is free, so a result is never overwritten
    assign o_ready = (r_state == S_IDLE) && !i_hold && !r_oval;
    assign o_valid = r_oval;
    assign o_blk   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_chain <= '0;
            r_rnd   <= '0;
            r_dec   <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        {r_x0, r_x1, r_x2, r_x3} <= blk_in;
                        r_cin   <= chain_use;
                        r_dec   <= !i_dir;
                        if (!i_dir) r_chain <= i_item.blk;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_x0  <= r_x1;
                    r_x1  <= r_x2;
                    r_x2  <= r_x3;
                    r_x3  <= nx;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == RndW'(NumRounds - 1)) begin
                        if (r_dec) begin
                            r_out <= {nx, r_x3, r_x2, r_x1} ^ r_cin;
                        end else begin
                            r_out   <= {nx, r_x3, r_x2, r_x1};
                            r_chain <= {nx, r_x3, r_x2, r_x1};
                        end
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/sm4c_regs.sv
// APB register file: key, IV and direction; starts key expansion on key writes.
// Depends on sm4c_pkg.
module sm4c_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sm4c_pkg::AddrW-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic [127:0]                o_key,
    output logic [127:0]                o_iv,
    output logic                        o_dir,
    output logic                        o_key_wr
);
    import sm4c_pkg::*;

    logic [63:0] r_kh, r_kl, r_ivh, r_ivl;
    logic        r_dir, r_key_wr;
    logic        wr;

    assign wr       = psel && penable && pwrite;
    assign o_key    = {r_kh, r_kl};
    assign o_iv     = {r_ivh, r_ivl};
    assign o_dir    = r_dir;
    assign o_key_wr = r_key_wr;

    always_comb begin
        unique case (paddr)
            RegKeyHigh: prdata = r_kh;
            RegKeyLow:  prdata = r_kl;
            RegIvHigh:  prdata = r_ivh;
            RegIvLow:   prdata = r_ivl;
            RegDir:     prdata = {63'h0, r_dir};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh <= '0; r_kl <= '0; r_ivh <= '0; r_ivl <= '0;
            r_dir <= 1'b1;
            r_key_wr <= 1'b0;
        end else begin
            r_key_wr <= 1'b0;
            if (wr) begin
                unique case (paddr)
                    RegKeyHigh: begin r_kh <= pwdata; r_key_wr <= 1'b1; end
                    RegKeyLow:  begin r_kl <= pwdata; r_key_wr <= 1'b1; end
                    RegIvHigh:  r_ivh <= pwdata;
                    RegIvLow:   r_ivl <= pwdata;
                    RegDir:     r_dir <= pwdata[0];
                    default:    ;
                endcase
            end
        end
    end
endmodule

// File: hdl/sm4_cbc_block_cipher.sv
// SM4-128 in CBC mode. Top level; ties the register file, input queue,
// key expansion and round engine together. Depends on sm4c_pkg.
//
// One 128-bit block per word, split into two big-endian 64-bit halves, with a
// restart flag that reloads the chaining value from the IV registers. Direction
// 1 encrypts (out = E(in ^ chain)), 0 decrypts (out = D(in) ^ chain). In the
// round engine a block first fetches the first round key from the round-key
// memory, then runs 32 SM4 rounds at one round per cycle. The engine starts the
// next block only after the previous result has left the output register, so
// it never takes a new block before it is through with the last one; the single
// round engine and the CBC dependence on the previous block set this limit. Up
// to two words queue in front of the engine while a block is in flight or a
// result waits, so the input side keeps taking words until that queue fills.
// Each key register write re-expands the 32 round keys; the engine does not
// start a block during expansion. Until the first key write the round keys are
// all zero. Registers sit at byte address 8*i over a 64-bit APB port: key_high,
// key_low, iv_high, iv_low, direction.
module sm4_cbc_block_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sm4c_pkg::AddrW-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [63:0]                 i_in_high,
    input  logic [63:0]                 i_in_low,
    input  logic                        i_restart,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_out_high,
    output logic [63:0]                 o_out_low
);
    import sm4c_pkg::*;

    logic [127:0]    key, iv, res;
    logic            dir, key_wr, kx_busy;
    logic [RndW-1:0] rk_idx;
    logic [31:0]     rk;
    t_item           in_item, q_item;
    logic            q_valid, q_ready;

    assign pready  = 1'b1;
    assign in_item = '{blk: {i_in_high, i_in_low}, restart: i_restart};

    sm4c_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .o_key(key), .o_iv(iv), .o_dir(dir), .o_key_wr(key_wr)
    );

    sm4c_keyexp u_kx (
        .i_clk, .i_rst_n, .i_start(key_wr), .i_key(key),
        .i_rd_idx(rk_idx), .o_rk(rk), .o_busy(kx_busy)
    );

    // hold the queue head while keys are rebuilt
    sm4c_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    sm4c_engine u_eng (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_hold(kx_busy || key_wr), .i_dir(dir), .i_iv(iv),
        .o_rk_idx(rk_idx), .i_rk(rk),
        .o_valid, .i_ready, .o_blk(res)
    );

    assign o_out_high = res[127:64];
    assign o_out_low  = res[63:0];
endmodule

// File: hdl/sm4c_checker.sv
// Port-level checker for sm4_cbc_block_cipher, bound to the top level.
// Watches handshake and result ports only; no package dependency.
module sm4c_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        pready,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [63:0]                 o_out_high,
    input  logic [63:0]                 o_out_low
);
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_high) && $stable(o_out_low))
        else $error("result dropped or changed while stalled");
    a_no_back2back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("results closer than one block time");
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_ready)
        else $error("not idle after reset");
endmodule

bind sm4_cbc_block_cipher sm4c_checker u_chk (
    .i_clk, .i_rst_n, .pready, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_out_high, .o_out_low
);

// File: dv/sm4_cbc_block_cipher_test.sv
// Self-checking testbench for sm4_cbc_block_cipher: a directed table, then random CBC traffic.
// A local SM4 predictor is checked against every result. Depends on sm4c_pkg and the RTL.
module sm4_cbc_block_cipher_test;
    import sm4c_pkg::*;

    localparam logic [AddrW-1:0] RegUnused = 6'h28;  // index five: write must be ignored
    localparam int StallLimit = 3000;
    localparam int SettleCycles = 80;                // engine plus key expansion

    typedef enum logic [1:0] {OpWord, OpWrite, OpDrain} t_op;

    typedef struct {
        t_op             op;
        logic [AddrW-1:0] addr;
        logic [63:0]     val;
        logic [63:0]     hi;
        logic [63:0]     lo;
        logic            rst;
        logic            chk;
        logic [63:0]     ehi;
        logic [63:0]     elo;
    } t_row;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    localparam logic [63:0] StdHi = 64'h0123456789abcdef;
    localparam logic [63:0] StdLo = 64'hfedcba9876543210;
    localparam logic [63:0] CtHi  = 64'h681edf34d206965e;
    localparam logic [63:0] CtLo  = 64'h86b3e94f536e4246;
    localparam logic [63:0] Ones  = '1;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [AddrW-1:0] paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_ready, i_restart, o_valid, i_ready;
    logic [63:0] i_in_high, i_in_low, o_out_high, o_out_low;

    sm4_cbc_block_cipher uut (.*);

    // predictor state
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo, chain_hi, chain_lo;
    logic        encrypt;
    logic [31:0] rkeys [32];

    t_block      pending_blocks[$];
    int          errors;
    int          stall_cnt;
    bit          calm;     // no idling on either side while set
    t_row        plan[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rot(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] subst(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] ck_word(input int i);
        logic [31:0] v;
        v = '0;
        for (int j = 0; j < 4; j++) v = {v[23:0], 8'((4 * i + j) * 7)};
        return v;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] k[4];
        logic [31:0] t, nk;
        k[0] = key_hi[63:32] ^ 32'ha3b1bac6;
        k[1] = key_hi[31:0]  ^ 32'h56aa3350;
        k[2] = key_lo[63:32] ^ 32'h677d9197;
        k[3] = key_lo[31:0]  ^ 32'hb27022dc;
        for (int i = 0; i < 32; i++) begin
            t = subst(k[1] ^ k[2] ^ k[3] ^ ck_word(i));
            nk = k[0] ^ t ^ rot(t, 13) ^ rot(t, 23);
            rkeys[i] = nk;
            k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
        end
    endfunction

    function automatic t_block sm4_rounds(input logic [127:0] blk, input bit reverse);
        logic [31:0] x[4];
        logic [31:0] t, nx;
        t_block r;
        {x[0], x[1], x[2], x[3]} = blk;
        for (int i = 0; i < 32; i++) begin
            t = subst(x[1] ^ x[2] ^ x[3] ^ rkeys[reverse ? 31 - i : i]);
            nx = x[0] ^ t ^ rot(t, 2) ^ rot(t, 10) ^ rot(t, 18) ^ rot(t, 24);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
        end
        {r.hi, r.lo} = {x[3], x[2], x[1], x[0]};
        return r;
    endfunction

    // Advance the chaining state by one block and return the block's result.
    function automatic t_block cbc_next(input logic [63:0] hi, input logic [63:0] lo,
                                        input logic rst);
        t_block r;
        if (rst) begin
            chain_hi = iv_hi;
            chain_lo = iv_lo;
        end
        if (encrypt) begin
            r = sm4_rounds({hi ^ chain_hi, lo ^ chain_lo}, 1'b0);
            chain_hi = r.hi;
            chain_lo = r.lo;
        end else begin
            r = sm4_rounds({hi, lo}, 1'b1);
            r.hi ^= chain_hi;
            r.lo ^= chain_lo;
            chain_hi = hi;
            chain_lo = lo;
        end
        return r;
    endfunction

    function automatic void shadow_write(input logic [AddrW-1:0] a, input logic [63:0] v);
        case (a)
            RegKeyHigh: begin key_hi = v; expand_round_keys(); end
            RegKeyLow:  begin key_lo = v; expand_round_keys(); end
            RegIvHigh:  iv_hi = v;
            RegIvLow:   iv_lo = v;
            RegDir:     encrypt = v[0];
            default: ;
        endcase
    endfunction

    // Setup phase, access phase, then an idle phase; caller sits at a rising edge.
    task automatic apb_write(input logic [AddrW-1:0] a, input logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        shadow_write(a, v);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every outstanding block has come back, then settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Present one word, hold it until accepted, then maybe idle.
    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input logic rst,
                             input bit chk, input logic [63:0] ehi, input logic [63:0] elo);
        t_block p;
        i_valid <= 1'b1; i_in_high <= hi; i_in_low <= lo; i_restart <= rst;
        do @(posedge i_clk); while (!o_ready);
        p = cbc_next(hi, lo, rst);
        if (chk && (p.hi !== ehi || p.lo !== elo)) begin
            $display("%0t predictor: expected %h_%h actual %h_%h", $time, ehi, elo, p.hi, p.lo);
            errors++;
        end
        if (chk) begin
            p.hi = ehi;
            p.lo = elo;
        end
        pending_blocks.push_back(p);
        if (!calm && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_op op, input logic [AddrW-1:0] a, input logic [63:0] v,
                           input logic [63:0] hi, input logic [63:0] lo, input logic rst,
                           input bit chk, input logic [63:0] ehi, input logic [63:0] elo);
        plan.push_back('{op, a, v, hi, lo, rst, chk, ehi, elo});
    endtask

    // Receive side: check the oldest expectation, then randomize ready.
    always @(posedge i_clk) begin
        t_block e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t unexpected word: actual %h_%h", $time, o_out_high, o_out_low);
                errors++;
            end else begin
                e = pending_blocks.pop_front();
                if (o_out_high !== e.hi) begin
                    $display("%0t out_high: expected %h actual %h", $time, e.hi, o_out_high);
                    errors++;
                end
                if (o_out_low !== e.lo) begin
                    $display("%0t out_low: expected %h actual %h", $time, e.lo, o_out_low);
                    errors++;
                end
            end
        end
        i_ready <= calm || ($urandom_range(99) >= 29);
    end

    // Watchdog: count cycles in which no word moves on either side and no APB access completes.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] v;
        errors = 0; stall_cnt = 0; calm = 1'b0;
        i_rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_in_high = '0; i_in_low = '0; i_restart = 1'b0; i_ready = 1'b0;
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; chain_hi = '0; chain_lo = '0;
        encrypt = 1'b1;
        foreach (rkeys[i]) rkeys[i] = '0;

        // Directed table: zero round keys first, then the standard vector both ways.
        add_row(OpWord, '0, '0, '0, '0, 1'b1, 0, '0, '0);
        add_row(OpWord, '0, '0, Ones, Ones, 1'b0, 0, '0, '0);
        add_row(OpDrain, '0, '0, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWrite, RegKeyHigh, StdHi, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWrite, RegKeyLow, StdLo, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWord, '0, '0, StdHi, StdLo, 1'b1, 1, CtHi, CtLo);
        add_row(OpWord, '0, '0, Ones, '0, 1'b0, 0, '0, '0);
        add_row(OpDrain, '0, '0, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWrite, RegDir, 64'hfffe, '0, '0, 1'b0, 0, '0, '0);  // only bit 0 counts
        add_row(OpWrite, RegUnused, Ones, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWord, '0, '0, CtHi, CtLo, 1'b1, 1, StdHi, StdLo);
        add_row(OpWord, '0, '0, '0, Ones, 1'b0, 0, '0, '0);
        add_row(OpDrain, '0, '0, '0, '0, 1'b0, 0, '0, '0);
        // new key and direction mid-message keep the chain
        add_row(OpWrite, RegKeyHigh, Ones, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWrite, RegDir, 64'h1, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWord, '0, '0, 64'h8000000000000001, 64'h1, 1'b0, 0, '0, '0);
        add_row(OpDrain, '0, '0, '0, '0, 1'b0, 0, '0, '0);
        // IV rewritten before a restart
        add_row(OpWrite, RegIvHigh, Ones, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWrite, RegIvLow, 64'h5555aaaa5555aaaa, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWrite, RegKeyLow, Ones, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpWord, '0, '0, Ones, Ones, 1'b1, 0, '0, '0);
        add_row(OpWord, '0, '0, '0, '0, 1'b0, 0, '0, '0);
        add_row(OpDrain, '0, '0, '0, '0, 1'b0, 0, '0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            case (plan[n].op)
                OpWord:  send_word(plan[n].hi, plan[n].lo, plan[n].rst, plan[n].chk,
                                   plan[n].ehi, plan[n].elo);
                OpWrite: apb_write(plan[n].addr, plan[n].val);
                default: drain();
            endcase
        end

        // Random phases: reconfigure while idle, then send messages of random blocks.
        for (int ph = 0; ph < 9; ph++) begin
            calm = (ph == 4);
            for (int r = 0; r < 5; r++) begin
                case ($urandom_range(3))
                    0: v = '0;
                    1: v = Ones;
                    default: v = {$urandom, $urandom};
                endcase
                apb_write(r == 0 ? RegKeyHigh : r == 1 ? RegKeyLow : r == 2 ? RegIvHigh :
                          r == 3 ? RegIvLow : RegDir, r == 4 ? 64'($urandom_range(1)) : v);
            end
            for (int k = 0; k < 94; k++)
                send_word({$urandom, $urandom}, {$urandom, $urandom},
                          k == 0 || $urandom_range(7) == 0, 0, '0, '0);
            drain();
        end
        calm = 1'b0;

        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
